/* rtl/swm_pkg.sv */
`timescale 1ns / 1ps
// swm_pkg: shared constants and types for the sliding window maximum block
// no dependencies

package swm_pkg;

    localparam int WINDOW_MAX_DEF = 64;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CFG_WIDTH      = 7;

    // per-cycle command broadcast to every deque cell
    typedef struct packed {
        logic shift;  // take the right neighbour's entry (front entry leaves)
        logic push;   // trim smaller entries and append the held word
        logic clr;    // new sequence: treat every stored entry as empty
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } state_t;

endpackage

/* rtl/swm_in_if.sv */
`timescale 1ns / 1ps
// swm_in_if: input word channel (sample and sequence start flag)
// depends on swm_pkg

interface swm_in_if import swm_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] sample;
    logic                  first;

    modport source (output valid, output sample, output first, input ready);
    modport sink   (input valid, input sample, input first, output ready);
endinterface

/* rtl/swm_out_if.sv */
`timescale 1ns / 1ps
// swm_out_if: result word channel (window maximum)
// depends on swm_pkg

interface swm_out_if import swm_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] window_max;

    modport source (output valid, output window_max, input ready);
    modport sink   (input valid, input window_max, output ready);
endinterface

/* rtl/swm_cell.sv */
`timescale 1ns / 1ps
// swm_cell: one deque cell holding a candidate value, its position and a valid bit
// depends on swm_pkg

module swm_cell import swm_pkg::*; #(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    localparam int POS_MOD   = 2 * WINDOW_MAX,
    localparam int PW        = $clog2(POS_MOD)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_ctrl_t            ctrl,
    input  logic [DATA_WIDTH-1:0] smp,
    input  logic [PW-1:0]         pos_cur,
    input  logic [PW-1:0]         win,
    input  logic [DATA_WIDTH-1:0] nb_val,
    input  logic [PW-1:0]         nb_pos,
    input  logic                  nb_vld,
    input  logic                  left_keep,
    output logic [DATA_WIDTH-1:0] val,
    output logic [PW-1:0]         pos,
    output logic                  vld,
    output logic                  expired,
    output logic                  keep
);

    logic [DATA_WIDTH-1:0] val_reg;
    logic [PW-1:0]         pos_reg;
    logic                  vld_reg;
    logic [DATA_WIDTH-1:0] src_val;
    logic [PW-1:0]         src_pos;
    logic                  src_vld;
    logic                  slot;
    logic [PW:0]           age;

    // distance back from the current position, modulo twice the largest window
    always_comb
    begin
        if (pos_cur >= pos_reg)
        begin
            age = {1'b0, pos_cur} - {1'b0, pos_reg};
        end
        else
        begin
            age = {1'b0, pos_cur} + (PW+1)'(POS_MOD) - {1'b0, pos_reg};
        end
    end

    assign expired = vld_reg && !ctrl.clr && (age >= {1'b0, win});

    assign src_val = ctrl.shift ? nb_val : val_reg;
    assign src_pos = ctrl.shift ? nb_pos : pos_reg;
    assign src_vld = (ctrl.shift ? nb_vld : vld_reg) && !ctrl.clr;

    // equal entries stay, only strictly smaller ones go
    assign keep = src_vld && !($signed(smp) > $signed(src_val));
    assign slot = !keep && left_keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (ctrl.push)
        begin
            vld_reg <= keep || slot;
        end
        else if (ctrl.shift)
        begin
            vld_reg <= nb_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            val_reg <= keep ? src_val : smp;
            pos_reg <= keep ? src_pos : pos_cur;
        end
        else if (ctrl.shift)
        begin
            val_reg <= nb_val;
            pos_reg <= nb_pos;
        end
    end

    assign val = val_reg;
    assign pos = pos_reg;
    assign vld = vld_reg;

endmodule

/* rtl/sliding_window_maximum_top.sv */
`timescale 1ns / 1ps
// sliding window maximum over a signed word stream, monotonic deque in a row of cells
// timing: the taken input word is registered; the result register then loads once any
// extra expired front entries left after the window size has been lowered are dropped
// throughput: one word per cycle, stalled by a pending out_ch result or a front drop
// reset: deque empty, position and sample count zero, window size one
// depends on swm_pkg, swm_in_if, swm_out_if, swm_cell

module sliding_window_maximum_top import swm_pkg::*; #(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_WIDTH-1:0] cfg_wdata,
    swm_in_if.sink               in_ch,
    swm_out_if.source            out_ch
);

    localparam int POS_MOD = 2 * WINDOW_MAX;
    localparam int PW      = $clog2(POS_MOD);
    localparam int SW      = $clog2(WINDOW_MAX + 1);

    state_t                state_reg, state_next;
    logic [CFG_WIDTH-1:0]  ws_reg;
    logic [DATA_WIDTH-1:0] smp_reg;
    logic                  first_reg;
    logic [PW-1:0]         pos_reg, pos_next;
    logic [SW-1:0]         seen_reg, seen_next;
    logic                  ov_reg;
    logic [DATA_WIDTH-1:0] wm_reg;

    logic [PW-1:0]         win;
    logic [PW-1:0]         pos_cur;
    logic                  busy, multi, emit, done, accept;
    logic [DATA_WIDTH-1:0] front;
    cell_ctrl_t            ctrl;

    logic [DATA_WIDTH-1:0] c_val [0:WINDOW_MAX];
    logic [PW-1:0]         c_pos [0:WINDOW_MAX];
    logic [WINDOW_MAX:0]   c_vld;
    logic [WINDOW_MAX:0]   c_exp;
    logic [WINDOW_MAX-1:0] c_keep;
    logic [WINDOW_MAX-1:0] vld_vec;

    // effective window: zero reads as one, large values saturate
    always_comb
    begin
        if (ws_reg == '0)
        begin
            win = PW'(1);
        end
        else if (32'(ws_reg) > WINDOW_MAX)
        begin
            win = PW'(WINDOW_MAX);
        end
        else
        begin
            win = PW'(ws_reg);
        end
    end

    assign busy    = (state_reg == ST_BUSY);
    assign pos_cur = first_reg ? '0 : pos_reg;

    always_comb
    begin
        if (first_reg)
        begin
            seen_next = SW'(1);
        end
        else if (32'(seen_reg) < WINDOW_MAX)
        begin
            seen_next = seen_reg + 1'b1;
        end
        else
        begin
            seen_next = seen_reg;
        end
        if (32'(pos_cur) + 1 == POS_MOD)
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_cur + 1'b1;
        end
    end

    // two expired front entries only after the window has shrunk: drop one a cycle
    assign multi  = c_exp[0] && c_exp[1];
    assign emit   = (32'(seen_next) >= 32'(win));
    assign done   = busy && !multi && (!emit || !ov_reg || out_ch.ready);
    assign accept = in_ch.valid && in_ch.ready;

    assign ctrl.shift = busy && (multi || (done && c_exp[0]));
    assign ctrl.push  = done;
    assign ctrl.clr   = first_reg;

    assign front = c_keep[0] ? (c_exp[0] ? c_val[1] : c_val[0]) : smp_reg;

    assign in_ch.ready       = (state_reg == ST_IDLE) || done;
    assign out_ch.valid      = ov_reg;
    assign out_ch.window_max = wm_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (done && !accept)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ws_reg    <= CFG_WIDTH'(1);
            pos_reg   <= '0;
            seen_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                ws_reg <= cfg_wdata;
            end
            if (done)
            begin
                pos_reg  <= pos_next;
                seen_reg <= seen_next;
            end
            if (done && emit)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            smp_reg   <= in_ch.sample;
            first_reg <= in_ch.first;
        end
        if (done && emit)
        begin
            wm_reg <= front;
        end
    end

    // empty slot past the back of the row
    assign c_val[WINDOW_MAX] = '0;
    assign c_pos[WINDOW_MAX] = '0;
    assign c_vld[WINDOW_MAX] = 1'b0;
    assign c_exp[WINDOW_MAX] = 1'b0;

    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        swm_cell #(
            .WINDOW_MAX (WINDOW_MAX),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .smp       (smp_reg),
            .pos_cur   (pos_cur),
            .win       (win),
            .nb_val    (c_val[i+1]),
            .nb_pos    (c_pos[i+1]),
            .nb_vld    (c_vld[i+1]),
            .left_keep ((i == 0) ? 1'b1 : c_keep[(i == 0) ? 0 : i-1]),
            .val       (c_val[i]),
            .pos       (c_pos[i]),
            .vld       (c_vld[i]),
            .expired   (c_exp[i]),
            .keep      (c_keep[i])
        );
    end

    assign vld_vec = c_vld[WINDOW_MAX-1:0];

    // occupied cells always form one run from the front
    a_compact: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_vec & (vld_vec + 1'b1)) == '0)
        else $error("deque cells not compacted to the front");

    // every completed word leaves an entry in the front cell
    a_front_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> c_vld[0])
        else $error("front cell empty after push");

    // a new word is never taken while the held one still has entries to drop
    a_no_take_mid_drop: assert property (@(posedge clk) disable iff (!rst_n)
        busy && in_ch.ready |-> !multi)
        else $error("word taken during front drop");

    // the row never fills up with every entry kept
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !c_keep[WINDOW_MAX-1])
        else $error("deque overflow on push");

endmodule
